>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, ignored while in reset
`define AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle, also across reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ferle_pkg.sv
// shared types, constants and helper functions of the erle estimator
package ferle_pkg;

  localparam int PWR_W  = 32;
  localparam int TOT_W  = 41;
  localparam int ACC_W  = 45;
  localparam int DIV_W  = ACC_W + 16;
  localparam int LOG_W  = 24;
  localparam int Q_W    = 17;
  localparam int HOLD_W = 18;
  localparam int CNT_W  = 4;
  localparam int CFG_W  = 41;
  localparam int CFG_IDX_W = 3;

  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam logic [Q_W-1:0]   Q16_ONE = 17'h10000;
  localparam logic signed [LOG_W-1:0] TRK_MAX_RST = -24'sd655360;
  localparam logic signed [LOG_W-1:0] TRK_MIN_RST = 24'sd2162688;

  localparam logic [CFG_IDX_W-1:0] CFG_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SM_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HPE    = 3'd6;

  typedef struct packed {
    logic             accept;
    logic [TOT_W-1:0] mic;
    logic [TOT_W-1:0] err;
  } hop_t;

  typedef struct packed {
    logic [TOT_W-1:0]        thr;
    logic [Q_W-1:0]          sm_alpha;
    logic [Q_W-1:0]          q_alpha;
    logic [Q_W-1:0]          forget;
    logic [15:0]             hold;
    logic signed [LOG_W-1:0] floor_log2;
    logic [CNT_W-1:0]        hpe;
  } cfg_t;

  function automatic logic signed [LOG_W-1:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end
    return v[LOG_W-1:0];
  endfunction

  function automatic logic [Q_W-1:0] clamp_alpha(input logic [Q_W-1:0] a);
    return (a > Q16_ONE) ? Q16_ONE : a;
  endfunction

  // rounded alpha * diff / 2^16, symmetric about zero
  function automatic logic signed [26:0] alpha_mul(input logic [Q_W-1:0] alpha,
                                                  input logic signed [25:0] diff);
    logic [25:0] mag;
    logic [42:0] prod;
    logic [26:0] r;
    mag  = diff[25] ? 26'(-diff) : 26'(diff);
    prod = 43'(alpha) * 43'(mag) + 43'd32768;
    r    = prod[42:16];
    return diff[25] ? -$signed(r) : $signed(r);
  endfunction

endpackage

>>> rtl/ferle_front.sv
// bin front end: sums bin powers and closes each hop into a queue word
module ferle_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [ferle_pkg::PWR_W-1:0]   in_far_power,
  input  logic [ferle_pkg::PWR_W-1:0]   in_mic_power,
  input  logic [ferle_pkg::PWR_W-1:0]   in_error_power,
  input  logic                          in_converged,
  input  logic                          in_last_bin,
  input  logic [ferle_pkg::TOT_W-1:0]   thr,
  input  logic                          q_full,
  output logic                          q_push,
  output ferle_pkg::hop_t               q_word
);

  logic [ferle_pkg::TOT_W-1:0] far_r, mic_r, err_r;
  logic [ferle_pkg::TOT_W-1:0] far_nxt, mic_nxt, err_nxt;
  logic [ferle_pkg::TOT_W:0]   far_s, mic_s, err_s;
  logic                        acc;

  assign acc   = in_push && !q_full;
  assign far_s = {1'b0, far_r} + (ferle_pkg::TOT_W+1)'(in_far_power);
  assign mic_s = {1'b0, mic_r} + (ferle_pkg::TOT_W+1)'(in_mic_power);
  assign err_s = {1'b0, err_r} + (ferle_pkg::TOT_W+1)'(in_error_power);
  assign far_nxt = far_s[ferle_pkg::TOT_W] ? ferle_pkg::TOT_MAX : far_s[ferle_pkg::TOT_W-1:0];
  assign mic_nxt = mic_s[ferle_pkg::TOT_W] ? ferle_pkg::TOT_MAX : mic_s[ferle_pkg::TOT_W-1:0];
  assign err_nxt = err_s[ferle_pkg::TOT_W] ? ferle_pkg::TOT_MAX : err_s[ferle_pkg::TOT_W-1:0];

  assign q_push        = acc && in_last_bin;
  assign q_word.accept = in_converged && (far_nxt > thr);
  assign q_word.mic    = mic_nxt;
  assign q_word.err    = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r <= '0;
      mic_r <= '0;
      err_r <= '0;
    end else if (acc) begin
      if (in_last_bin) begin
        far_r <= '0;
        mic_r <= '0;
        err_r <= '0;
      end else begin
        far_r <= far_nxt;
        mic_r <= mic_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule

>>> rtl/ferle_fifo.sv
// four-word queue of closed hops between front and back end
module ferle_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ferle_pkg::hop_t wdata,
  input  logic            pop,
  output ferle_pkg::hop_t rdata,
  output logic            full,
  output logic            empty
);

  ferle_pkg::hop_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 2'd1;
      if (do_pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

>>> rtl/ferle_back.sv
// hop back end: accumulation, shared divider, log2, trackers, smoothing, result word
module ferle_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ferle_pkg::cfg_t                     cfg,
  input  logic                                q_empty,
  input  ferle_pkg::hop_t                     q_word,
  output logic                                q_pop,
  input  logic                                out_pop,
  output logic                                out_empty,
  output logic signed [ferle_pkg::LOG_W-1:0]  out_smooth_erle,
  output logic [ferle_pkg::Q_W-1:0]           out_quality,
  output logic                                out_quality_valid,
  output logic                                out_estimate_updated
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_DIV    = 4'd2;
  localparam logic [3:0] ST_NORM   = 4'd3;
  localparam logic [3:0] ST_SQR    = 4'd4;
  localparam logic [3:0] ST_TRACK  = 4'd5;
  localparam logic [3:0] ST_QPREP  = 4'd6;
  localparam logic [3:0] ST_QUAL   = 4'd7;
  localparam logic [3:0] ST_SMOOTH = 4'd8;
  localparam logic [3:0] ST_HOLD   = 4'd9;

  logic [3:0]                          st_r;
  logic [ferle_pkg::ACC_W-1:0]         mic_acc_r, err_acc_r;
  logic [ferle_pkg::CNT_W-1:0]         hop_cnt_r;
  logic                                accept_r, upd_r, qmode_r;
  logic [ferle_pkg::DIV_W-1:0]         div_q_r;
  logic [ferle_pkg::ACC_W-1:0]         div_rem_r, div_den_r;
  logic [5:0]                          div_cnt_r, log_n_r;
  logic [31:0]                         m_r;
  logic [15:0]                         frac_r;
  logic [3:0]                          sq_cnt_r;
  logic signed [ferle_pkg::LOG_W-1:0]  inst_r, max_r, min_r, sm_r;
  logic                                known_r;
  logic [ferle_pkg::Q_W-1:0]           qe_r;
  logic signed [ferle_pkg::HOLD_W-1:0] hold_r;
  logic                                ovalid_r;

  logic [ferle_pkg::ACC_W:0]           mic_s, err_s;
  logic [ferle_pkg::CNT_W-1:0]         need;
  logic [ferle_pkg::ACC_W:0]           rem_sh;
  logic                                ge;
  logic [ferle_pkg::ACC_W:0]           rem_n;
  logic [63:0]                         sq;
  logic [32:0]                         sq_t;
  logic [15:0]                         frac_nxt;
  logic signed [ferle_pkg::LOG_W-1:0]  max_nxt, min_nxt, max_dec, min_inc;
  logic signed [24:0]                  ld, dd;
  logic [ferle_pkg::Q_W-1:0]           qv;
  logic signed [26:0]                  qe_sum, sm_sum, sm_fl;
  logic signed [ferle_pkg::HOLD_W-1:0] hold_nxt;

  assign q_pop     = (st_r == ST_IDLE) && !q_empty && !ovalid_r;
  assign out_empty = !ovalid_r;

  assign mic_s = {1'b0, mic_acc_r} + (ferle_pkg::ACC_W+1)'(q_word.mic);
  assign err_s = {1'b0, err_acc_r} + (ferle_pkg::ACC_W+1)'(q_word.err);
  assign need  = (cfg.hpe == '0) ? ferle_pkg::CNT_W'(1) : cfg.hpe;

  // restoring divider step, quotient bits enter at the bottom of div_q_r
  assign rem_sh = {div_rem_r, div_q_r[ferle_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, div_den_r};
  assign rem_n  = ge ? (rem_sh - {1'b0, div_den_r}) : rem_sh;

  // log2 fraction by repeated squaring
  assign sq       = 64'(m_r) * 64'(m_r);
  assign sq_t     = sq[63:31];
  assign frac_nxt = {frac_r[14:0], sq_t[32]};

  assign max_dec = ferle_pkg::sat24(27'(max_r) - $signed({10'b0, cfg.forget}));
  assign min_inc = ferle_pkg::sat24(27'(min_r) + $signed({10'b0, cfg.forget}));
  assign max_nxt = (inst_r > max_dec) ? inst_r : max_dec;
  assign min_nxt = (inst_r < min_inc) ? inst_r : min_inc;
  assign ld      = 25'(inst_r) - 25'(min_r);
  assign dd      = 25'(max_r) - 25'(min_r);

  assign qv     = div_q_r[ferle_pkg::Q_W-1:0];
  assign qe_sum = 27'($signed({1'b0, qe_r})) + ferle_pkg::alpha_mul(
                    ferle_pkg::clamp_alpha(cfg.q_alpha),
                    26'($signed({1'b0, qv})) - 26'($signed({1'b0, qe_r})));
  assign sm_sum = 27'(sm_r) + ferle_pkg::alpha_mul(
                    ferle_pkg::clamp_alpha(cfg.sm_alpha), 26'(inst_r) - 26'(sm_r));
  assign sm_fl  = (sm_sum < 27'(cfg.floor_log2)) ? 27'(cfg.floor_log2) : sm_sum;

  assign hold_nxt = hold_r[ferle_pkg::HOLD_W-1] ? hold_r : (hold_r - 18'sd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      mic_acc_r <= '0;
      err_acc_r <= '0;
      hop_cnt_r <= '0;
      accept_r  <= 1'b0;
      upd_r     <= 1'b0;
      qmode_r   <= 1'b0;
      inst_r    <= '0;
      known_r   <= 1'b0;
      max_r     <= ferle_pkg::TRK_MAX_RST;
      min_r     <= ferle_pkg::TRK_MIN_RST;
      qe_r      <= '0;
      sm_r      <= '0;
      hold_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            accept_r <= q_word.accept;
            upd_r    <= 1'b0;
            if (q_word.accept) begin
              mic_acc_r <= mic_s[ferle_pkg::ACC_W] ? ferle_pkg::ACC_MAX
                                                   : mic_s[ferle_pkg::ACC_W-1:0];
              err_acc_r <= err_s[ferle_pkg::ACC_W] ? ferle_pkg::ACC_MAX
                                                   : err_s[ferle_pkg::ACC_W-1:0];
              hop_cnt_r <= hop_cnt_r + ferle_pkg::CNT_W'(1);
            end
            st_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (accept_r && (hop_cnt_r >= need)) begin
            hop_cnt_r <= '0;
            mic_acc_r <= '0;
            err_acc_r <= '0;
            if (err_acc_r != '0) begin
              upd_r     <= 1'b1;
              qmode_r   <= 1'b0;
              div_q_r   <= {mic_acc_r, 16'b0};
              div_den_r <= err_acc_r;
              div_rem_r <= '0;
              div_cnt_r <= '0;
              st_r      <= ST_DIV;
            end else begin
              st_r <= ST_HOLD;
            end
          end else begin
            st_r <= ST_HOLD;
          end
        end
        ST_DIV: begin
          div_rem_r <= rem_n[ferle_pkg::ACC_W-1:0];
          div_q_r   <= {div_q_r[ferle_pkg::DIV_W-2:0], ge};
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'(ferle_pkg::DIV_W-1)) begin
            log_n_r <= 6'(ferle_pkg::DIV_W-1);
            st_r    <= qmode_r ? ST_QUAL : ST_NORM;
          end
        end
        ST_NORM: begin
          // zero ratio counts as one lsb
          if (div_q_r == '0) begin
            div_q_r <= ferle_pkg::DIV_W'(1);
          end else if (!div_q_r[ferle_pkg::DIV_W-1]) begin
            div_q_r <= {div_q_r[ferle_pkg::DIV_W-2:0], 1'b0};
            log_n_r <= log_n_r - 6'd1;
          end else begin
            m_r      <= div_q_r[ferle_pkg::DIV_W-1 -: 32];
            frac_r   <= '0;
            sq_cnt_r <= '0;
            st_r     <= ST_SQR;
          end
        end
        ST_SQR: begin
          m_r      <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
          frac_r   <= frac_nxt;
          sq_cnt_r <= sq_cnt_r + 4'd1;
          if (sq_cnt_r == 4'd15) begin
            inst_r  <= {8'(log_n_r) - 8'd16, frac_nxt};
            known_r <= 1'b1;
            st_r    <= ST_TRACK;
          end
        end
        ST_TRACK: begin
          max_r <= max_nxt;
          min_r <= min_nxt;
          st_r  <= ST_QPREP;
        end
        ST_QPREP: begin
          if (max_r > min_r) begin
            qmode_r   <= 1'b1;
            div_q_r   <= ferle_pkg::DIV_W'({ld, 16'b0});
            div_den_r <= ferle_pkg::ACC_W'({dd});
            div_rem_r <= '0;
            div_cnt_r <= '0;
            st_r      <= ST_DIV;
          end else begin
            div_q_r <= '0;
            st_r    <= ST_QUAL;
          end
        end
        ST_QUAL: begin
          qe_r <= (qv > qe_r) ? qv : qe_sum[ferle_pkg::Q_W-1:0];
          st_r <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          sm_r   <= ferle_pkg::sat24(sm_fl);
          hold_r <= ferle_pkg::HOLD_W'(cfg.hold);
          st_r   <= ST_HOLD;
        end
        ST_HOLD: begin
          hold_r               <= hold_nxt;
          out_smooth_erle      <= sm_r;
          out_estimate_updated <= upd_r;
          if (hold_nxt == '0) begin
            known_r           <= 1'b0;
            inst_r            <= '0;
            qe_r              <= '0;
            hop_cnt_r         <= '0;
            mic_acc_r         <= '0;
            err_acc_r         <= '0;
            out_quality       <= '0;
            out_quality_valid <= 1'b0;
          end else begin
            out_quality       <= known_r ? qe_r : '0;
            out_quality_valid <= known_r;
          end
          ovalid_r <= 1'b1;
          st_r     <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/fullband_erle_estimator_unit.sv
// top level of the fullband erle estimator: config registers, front, queue, back
//
//  channel  direction  handshake          payload
//  in       in         in_push/in_full    far, mic, error power, converged, last bin
//  out      out        out_pop/out_empty  smooth_erle, quality, flags
//  cfg      in         cfg_wr_en          cfg_index, cfg_wdata
//
// bins are taken back to back while the queue is not full, and held while it is
// closed hops wait in a four-word queue; in_full rises only when it is full
// a hop without estimate passes check and hold; one with an estimate passes check,
// divide, normalise, squaring to 16 bits, track, a second divide if max is
// above min, quality, smooth, hold; a hop starts only when the result word is free
// synchronous active-low reset, no clearing pass
module fullband_erle_estimator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [ferle_pkg::PWR_W-1:0]         in_far_power,
  input  logic [ferle_pkg::PWR_W-1:0]         in_mic_power,
  input  logic [ferle_pkg::PWR_W-1:0]         in_error_power,
  input  logic                                in_converged,
  input  logic                                in_last_bin,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [ferle_pkg::LOG_W-1:0]  out_smooth_erle,
  output logic [ferle_pkg::Q_W-1:0]           out_quality,
  output logic                                out_quality_valid,
  output logic                                out_estimate_updated,
  input  logic                                cfg_wr_en,
  input  logic [ferle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ferle_pkg::CFG_W-1:0]         cfg_wdata
);

  ferle_pkg::cfg_t cfg_r;
  ferle_pkg::hop_t q_wword, q_rword;
  logic            q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr        <= '0;
      cfg_r.sm_alpha   <= 17'd3277;
      cfg_r.q_alpha    <= 17'd4588;
      cfg_r.forget     <= 17'd655;
      cfg_r.hold       <= 16'd40;
      cfg_r.floor_log2 <= '0;
      cfg_r.hpe        <= 4'd6;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ferle_pkg::CFG_THR:    cfg_r.thr        <= cfg_wdata;
        ferle_pkg::CFG_SM_A:   cfg_r.sm_alpha   <= cfg_wdata[16:0];
        ferle_pkg::CFG_Q_A:    cfg_r.q_alpha    <= cfg_wdata[16:0];
        ferle_pkg::CFG_FORGET: cfg_r.forget     <= cfg_wdata[16:0];
        ferle_pkg::CFG_HOLD:   cfg_r.hold       <= cfg_wdata[15:0];
        ferle_pkg::CFG_FLOOR:  cfg_r.floor_log2 <= $signed(cfg_wdata[23:0]);
        ferle_pkg::CFG_HPE:    cfg_r.hpe        <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign in_full = q_full;

  ferle_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_far_power   (in_far_power),
    .in_mic_power   (in_mic_power),
    .in_error_power (in_error_power),
    .in_converged   (in_converged),
    .in_last_bin    (in_last_bin),
    .thr            (cfg_r.thr),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_word         (q_wword)
  );

  ferle_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wword),
    .pop   (q_pop),
    .rdata (q_rword),
    .full  (q_full),
    .empty (q_empty)
  );

  ferle_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_empty              (q_empty),
    .q_word               (q_rword),
    .q_pop                (q_pop),
    .out_pop              (out_pop),
    .out_empty            (out_empty),
    .out_smooth_erle      (out_smooth_erle),
    .out_quality          (out_quality),
    .out_quality_valid    (out_quality_valid),
    .out_estimate_updated (out_estimate_updated)
  );

endmodule

>>> rtl/ferle_checker.sv
// port-level checks of the erle estimator and their bind
`include "assert_macros.svh"

module ferle_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_empty,
  input logic [ferle_pkg::Q_W-1:0]           out_quality,
  input logic                                out_quality_valid,
  input logic                                out_estimate_updated
);

  `AST_NEXT(a_empty_after_rst, !rst_n, out_empty)
  `AST_NOW(a_q_zero_when_invalid, !out_empty && !out_quality_valid, out_quality == '0)
  `AST_NOW(a_q_range, !out_empty, out_quality <= ferle_pkg::Q16_ONE)
  `AST_NOW(a_upd_needs_est, !out_empty && out_estimate_updated, out_quality_valid || out_quality == '0)

endmodule

bind fullband_erle_estimator_unit ferle_checker u_ferle_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_empty            (out_empty),
  .out_quality          (out_quality),
  .out_quality_valid    (out_quality_valid),
  .out_estimate_updated (out_estimate_updated)
);
